// ----- src/aes_pkg.sv -----
// AES-256 engine package: shared types, register codes, S-box tables and round functions.
// It has no dependencies; every module of the engine except aes_ram and aes_checker uses it.
package aes_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int NUM_RKEYS   = ROUND_COUNT + 1;
  localparam int NUM_WORDS   = 4 * NUM_RKEYS;
  localparam int RK_AW       = $clog2(NUM_RKEYS);
  localparam int WIDX_W      = $clog2(NUM_WORDS);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_NONCE_HI  = 3'd4,
    REG_NONCE_LO  = 3'd5,
    REG_MODE      = 3'd6,
    REG_DIRECTION = 3'd7
  } cfg_reg_t;

  // One configuration write.
  typedef struct packed {
    logic                  we;
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One classified block waiting for the round unit.
  typedef struct packed {
    logic [127:0] blk;   // block fed to the cipher
    logic [127:0] pad;   // data XORed into the cipher output in CTR mode
    logic         last;
    logic         ctr;
    logic         dec;
  } q_entry_t;

  // Round unit sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_HOLD
  } bk_state_t;

  localparam logic [2047:0] SBOX_FWD = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] SBOX_INV = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] x, input logic inv);
    logic [10:0] pos;
    pos = {~x, 3'b111};
    return inv ? SBOX_INV[pos -: 8] : SBOX_FWD[pos -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24], 1'b0), sbox(w[23:16], 1'b0),
            sbox(w[15:8], 1'b0), sbox(w[7:0], 1'b0)};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  // Multiply by a small constant in GF(2^8).
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    return r;
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = sbox(s[127-8*i -: 8], inv);
    end
    return t;
  endfunction

  // Byte r + 4c sits in row r, column c.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int mv;
    int st;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mv = r + 4 * ((c + r) % 4);
        st = r + 4 * c;
        if (inv) t[127-8*mv -: 8] = s[127-8*st -: 8];
        else     t[127-8*st -: 8] = s[127-8*mv -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0]   m [4];
    logic [7:0]   v;
    t = '0;
    if (inv) begin
      m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
    end else begin
      m[0] = 4'd2;  m[1] = 4'd3;  m[2] = 4'd1;  m[3] = 4'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v = v ^ gmul(s[127-8*(4*c+k) -: 8], m[(k - r + 4) % 4]);
        end
        t[127-8*(4*c+r) -: 8] = v;
      end
    end
    return t;
  endfunction

endpackage

// ----- src/aes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/aes_front.sv -----
// Front end: accepts input blocks, holds nonce, mode and direction, keeps the CTR counter
// and classifies each block into a queue entry. Depends on aes_pkg.
module aes_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aes_pkg::cfg_wr_t       cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [63:0]            in_data_high,
  input  logic [63:0]            in_data_low,
  input  logic                   in_last_block,
  input  logic                   q_full,
  output logic                   q_push,
  output aes_pkg::q_entry_t      q_wdata
);

  logic [127:0] nonce_r;
  logic [127:0] counter_r;
  logic [127:0] counter_nxt;
  logic         mode_r;
  logic         dir_r;
  logic [127:0] data;

  assign data     = {in_data_high, in_data_low};
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the block: CTR ciphers the counter and keeps the data as pad.
  always_comb begin
    q_wdata.last = in_last_block;
    q_wdata.ctr  = mode_r;
    q_wdata.dec  = dir_r && !mode_r;
    q_wdata.pad  = data;
    q_wdata.blk  = mode_r ? counter_r : data;
  end

  // Counter advances on CTR transfers, reloads from the nonce after a last block,
  // and takes a nonce half when that half is written.
  always_comb begin
    counter_nxt = counter_r;
    if (q_push) begin
      if (in_last_block) counter_nxt = nonce_r;
      else if (mode_r)   counter_nxt = counter_r + 128'd1;
    end
    if (cfg.we && cfg.index == aes_pkg::REG_NONCE_HI) counter_nxt[127:64] = cfg.data;
    if (cfg.we && cfg.index == aes_pkg::REG_NONCE_LO) counter_nxt[63:0]   = cfg.data;
  end

  // Configuration registers and counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonce_r   <= '0;
      counter_r <= '0;
      mode_r    <= 1'b0;
      dir_r     <= 1'b0;
    end else begin
      counter_r <= counter_nxt;
      if (cfg.we) begin
        unique case (cfg.index)
          aes_pkg::REG_NONCE_HI:  nonce_r[127:64] <= cfg.data;
          aes_pkg::REG_NONCE_LO:  nonce_r[63:0]   <= cfg.data;
          aes_pkg::REG_MODE:      mode_r <= cfg.data[0];
          aes_pkg::REG_DIRECTION: dir_r  <= cfg.data[0];
          aes_pkg::REG_KEY0, aes_pkg::REG_KEY1,
          aes_pkg::REG_KEY2, aes_pkg::REG_KEY3: ;
        endcase
      end
    end
  end

endmodule

// ----- src/aes_fifo.sv -----
// Short queue of classified blocks between the front end and the round unit.
// Depends on aes_pkg.
module aes_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aes_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output aes_pkg::q_entry_t rdata
);

  aes_pkg::q_entry_t                mem_r [aes_pkg::QDEPTH];
  logic [aes_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [aes_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [aes_pkg::QCNT_W-1:0]       count_r;

  assign full      = (count_r == aes_pkg::QCNT_W'(aes_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count; depth is a power of two so pointers wrap by themselves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- src/aes_keysched.sv -----
// Key schedule: holds the 256-bit key and expands it one 32-bit word per cycle into the
// round key memories after reset and after every key write. Depends on aes_pkg.
module aes_keysched (
  input  logic                      clk,
  input  logic                      rst_n,
  input  aes_pkg::cfg_wr_t          cfg,
  output logic                      busy,
  output logic                      rk_we_hi,
  output logic                      rk_we_lo,
  output logic [aes_pkg::RK_AW-1:0] rk_waddr,
  output logic [63:0]               rk_wdata
);

  logic [63:0]                 key_r [4];
  logic [31:0]                 win_r [8];
  logic [31:0]                 prev_r;
  logic [7:0]                  rcon_r;
  logic [aes_pkg::WIDX_W-1:0]  idx_r;
  logic                        busy_r;
  logic [31:0]                 word;
  logic [31:0]                 tmp;
  logic                        key_wr;

  assign key_wr = cfg.we && (cfg.index == aes_pkg::REG_KEY0 || cfg.index == aes_pkg::REG_KEY1 ||
                             cfg.index == aes_pkg::REG_KEY2 || cfg.index == aes_pkg::REG_KEY3);

  // Next expanded word: key words first, then the AES-256 recurrence.
  always_comb begin
    tmp = win_r[7];
    if (idx_r < aes_pkg::WIDX_W'(8)) begin
      word = idx_r[0] ? key_r[idx_r[2:1]][31:0] : key_r[idx_r[2:1]][63:32];
    end else begin
      if (idx_r[2:0] == 3'd0) begin
        tmp = aes_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_r, 24'h000000};
      end else if (idx_r[2:0] == 3'd4) begin
        tmp = aes_pkg::sub_word(tmp);
      end
      word = win_r[0] ^ tmp;
    end
  end

  // Every second word completes one half of a round key.
  assign busy     = busy_r;
  assign rk_we_hi = busy_r && idx_r[0] && !idx_r[1];
  assign rk_we_lo = busy_r && idx_r[0] && idx_r[1];
  assign rk_waddr = idx_r[aes_pkg::WIDX_W-1:2];
  assign rk_wdata = {prev_r, word};

  // Key registers and the expansion window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      busy_r <= 1'b1;
      idx_r  <= '0;
      rcon_r <= 8'h01;
    end else if (key_wr) begin
      key_r[cfg.index[1:0]] <= cfg.data;
      busy_r <= 1'b1;
      idx_r  <= '0;
      rcon_r <= 8'h01;
    end else if (busy_r) begin
      for (int i = 0; i < 7; i++) win_r[i] <= win_r[i+1];
      win_r[7] <= word;
      prev_r   <= word;
      if (idx_r >= aes_pkg::WIDX_W'(8) && idx_r[2:0] == 3'd0) begin
        rcon_r <= aes_pkg::xtime(rcon_r);
      end
      if (idx_r == aes_pkg::WIDX_W'(aes_pkg::NUM_WORDS - 1)) busy_r <= 1'b0;
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

// ----- src/aes_back.sv -----
// Back end: one shared AES round unit that runs the key addition and 14 rounds of a
// queued block, then loads the output register. Depends on aes_pkg.
module aes_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ks_busy,
  input  logic                      q_not_empty,
  input  aes_pkg::q_entry_t         q_rdata,
  output logic                      q_pop,
  output logic [aes_pkg::RK_AW-1:0] rk_raddr,
  input  logic [63:0]               rk_hi,
  input  logic [63:0]               rk_lo,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [63:0]               out_result_high,
  output logic [63:0]               out_result_low,
  output logic                      out_result_last
);

  localparam logic [aes_pkg::RK_AW-1:0] LAST_STEP = aes_pkg::RK_AW'(aes_pkg::ROUND_COUNT);

  aes_pkg::bk_state_t        state_r;
  aes_pkg::bk_state_t        state_nxt;
  aes_pkg::q_entry_t         ent_r;
  logic [aes_pkg::RK_AW-1:0] step_r;
  logic [aes_pkg::RK_AW-1:0] step_next;
  logic [127:0]              s_r;
  logic [127:0]              rnd;
  logic [127:0]              rkey;
  logic [127:0]              t;
  logic                      out_valid_r;
  logic [127:0]              out_r;
  logic                      out_last_r;
  logic                      slot_free;
  logic                      load_out;

  assign rkey      = {rk_hi, rk_lo};
  assign slot_free = !out_valid_r || !out_stall;
  assign step_next = (step_r == LAST_STEP) ? '0 : step_r + 1'b1;

  // One cipher step: key addition first, then full rounds, the last without MixColumns.
  always_comb begin
    t   = '0;
    rnd = s_r ^ rkey;
    if (step_r != '0) begin
      if (ent_r.dec) begin
        t   = aes_pkg::sub_bytes(aes_pkg::shift_rows(s_r, 1'b1), 1'b1) ^ rkey;
        rnd = (step_r == LAST_STEP) ? t : aes_pkg::mix_columns(t, 1'b1);
      end else begin
        t   = aes_pkg::shift_rows(aes_pkg::sub_bytes(s_r, 1'b0), 1'b0);
        rnd = ((step_r == LAST_STEP) ? t : aes_pkg::mix_columns(t, 1'b0)) ^ rkey;
      end
    end
  end

  // Sequencer: round key reads run one step ahead of the round unit.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    rk_raddr  = '0;
    unique case (state_r)
      aes_pkg::BK_IDLE: begin
        rk_raddr = q_rdata.dec ? LAST_STEP : '0;
        if (q_not_empty && !ks_busy) begin
          q_pop     = 1'b1;
          state_nxt = aes_pkg::BK_RUN;
        end
      end
      aes_pkg::BK_RUN: begin
        rk_raddr = ent_r.dec ? (LAST_STEP - step_next) : step_next;
        if (step_r == LAST_STEP) state_nxt = aes_pkg::BK_HOLD;
      end
      aes_pkg::BK_HOLD: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = aes_pkg::BK_IDLE;
        end
      end
      default: state_nxt = aes_pkg::BK_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r  <= q_rdata;
      s_r    <= q_rdata.blk;
      step_r <= '0;
    end else if (state_r == aes_pkg::BK_RUN) begin
      s_r    <= rnd;
      step_r <= step_next;
    end
    if (load_out) begin
      out_r      <= ent_r.ctr ? (s_r ^ ent_r.pad) : s_r;
      out_last_r <= ent_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = out_r[127:64];
  assign out_result_low  = out_r[63:0];
  assign out_result_last = out_last_r;

endmodule

// ----- src/aes256_ecb_ctr_engine_top.sv -----
// Top level of the AES-256 ECB/CTR engine: front end, queue, key schedule, round key
// memories and round unit. Depends on aes_pkg and every aes_* module except aes_checker.
//
//   Channel  | Direction | Handshake            | Payload
//   in_      | input     | in_valid / in_stall  | data_high, data_low, last_block
//   out_     | output    | out_valid / out_stall| result_high, result_low, result_last
//   cfg_     | input     | cfg_we               | cfg_index, cfg_data
//
// In the round unit a block passes through a queue pop, 15 steps of the shared round
// unit (key addition plus 14 rounds) and the output register load, which waits on out_stall.
// After reset and after any key write the key schedule expands all 60 round key words;
// queued blocks wait for it. Reset is synchronous, active low.
// A two-entry queue lets the front accept blocks while the round unit or output stalls.
module aes256_ecb_ctr_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic        out_result_last
);

  aes_pkg::cfg_wr_t          cfg;
  aes_pkg::q_entry_t         q_wdata;
  aes_pkg::q_entry_t         q_rdata;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_not_empty;
  logic                      ks_busy;
  logic                      rk_we_hi;
  logic                      rk_we_lo;
  logic [aes_pkg::RK_AW-1:0] rk_waddr;
  logic [63:0]               rk_wdata;
  logic [aes_pkg::RK_AW-1:0] rk_raddr;
  logic [63:0]               rk_hi;
  logic [63:0]               rk_lo;

  // Configuration write bundle.
  always_comb begin
    cfg.we    = cfg_we;
    cfg.index = aes_pkg::cfg_reg_t'(cfg_index);
    cfg.data  = cfg_data;
  end

  aes_front u_front (
    .clk, .rst_n, .cfg,
    .in_valid, .in_stall, .in_data_high, .in_data_low, .in_last_block,
    .q_full, .q_push, .q_wdata
  );

  aes_fifo u_fifo (
    .clk, .rst_n,
    .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .rdata(q_rdata)
  );

  aes_keysched u_keysched (
    .clk, .rst_n, .cfg,
    .busy(ks_busy), .rk_we_hi, .rk_we_lo, .rk_waddr, .rk_wdata
  );

  // Upper and lower halves of the fifteen round keys.
  aes_ram #(.WIDTH(64), .DEPTH(aes_pkg::NUM_RKEYS)) u_rk_hi (
    .clk, .we(rk_we_hi), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_hi)
  );

  aes_ram #(.WIDTH(64), .DEPTH(aes_pkg::NUM_RKEYS)) u_rk_lo (
    .clk, .we(rk_we_lo), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_lo)
  );

  aes_back u_back (
    .clk, .rst_n, .ks_busy,
    .q_not_empty, .q_rdata, .q_pop,
    .rk_raddr, .rk_hi, .rk_lo,
    .out_valid, .out_stall, .out_result_high, .out_result_low, .out_result_last
  );

endmodule

// ----- src/aes_checker.sv -----
// Port-level checks for the AES-256 engine, attached to the top level by bind.
// Depends only on the top level's ports.
module aes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_high,
  input logic        out_result_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its high half and its last flag unchanged.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_high) && $stable(out_result_last))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Reset empties the queue, so the input is open right after it.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind aes256_ecb_ctr_engine_top aes_checker u_aes_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_result_high, .out_result_last
);
